### rtl/core/iemr_pkg.sv
// Shared types and constants of the ICMP echo reply matcher.
package iemr_pkg;

	typedef struct packed {
		logic [7:0]  packet_byte;
		logic        is_last;
		logic [31:0] recv_seconds;
		logic [19:0] recv_microseconds;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         verdict;
		logic signed [31:0] round_trip_us;
	} out_word_t;

	typedef enum logic [2:0] {
		VERDICT_ACCEPTED    = 3'd0,
		VERDICT_NOT_ICMP    = 3'd1,
		VERDICT_TOO_SHORT   = 3'd2,
		VERDICT_NOT_REPLY   = 3'd3,
		VERDICT_ID_MISMATCH = 3'd4,
		VERDICT_SHORT_REPLY = 3'd5
	} verdict_t;

	// Packet summary handed on when the last byte is taken
	typedef struct packed {
		logic        short_packet;   // under 10 bytes
		logic        short_icmp;     // ICMP part under 8 bytes
		logic        short_reply;    // ICMP part under 16 bytes
		logic [7:0]  protocol_byte;
		logic [7:0]  message_type;
		logic [15:0] echo_identifier;
		logic [31:0] sent_seconds;
		logic [31:0] sent_microseconds;
		logic [31:0] recv_seconds;
		logic [19:0] recv_microseconds;
	} summary_t;

	// Verdict plus the two halves of the round-trip sum
	typedef struct packed {
		logic [2:0]         verdict;
		logic signed [53:0] sec_product;
		logic signed [32:0] usec_diff;
	} partial_t;

	localparam int unsigned        MIN_PACKET_BYTES = 10;
	localparam int unsigned        ICMP_HDR_BYTES   = 8;
	localparam int unsigned        ICMP_TS_END      = 16;
	localparam int unsigned        PROTO_BYTE_POS   = 9;
	localparam int unsigned        OFF_TYPE         = 0;
	localparam int unsigned        OFF_ID_LO        = 4;
	localparam int unsigned        OFF_ID_HI        = 5;
	localparam int unsigned        OFF_SEC_WORD     = 2;   // offsets 8..11, in 4-byte units
	localparam int unsigned        OFF_USEC_WORD    = 3;   // offsets 12..15
	localparam logic [7:0]         PROTO_ICMP       = 8'd1;
	localparam logic [7:0]         TYPE_ECHO_REPLY  = 8'd0;
	localparam logic signed [20:0] USEC_PER_SEC     = 21'sd1000000;

endpackage

### rtl/core/iemr_capture.sv
// Byte counter and header field capture; registers a packet summary on the last byte.
module iemr_capture #(
	parameter int unsigned MAX_PACKET_BYTES = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  iemr_pkg::in_word_t in_data,
	output logic               sum_valid,
	input  logic               sum_ready,
	output iemr_pkg::summary_t sum_data
);
	import iemr_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);

	logic [CNT_W-1:0] byte_count_q, count_n;
	logic [5:0]       header_length_q, hl_n;
	logic [7:0]       protocol_q, protocol_n;
	logic [7:0]       type_q, type_n;
	logic [15:0]      ident_q, ident_n;
	logic [31:0]      sent_s_q, sent_s_n;
	logic [31:0]      sent_us_q, sent_us_n;
	logic [CNT_W-1:0] off;
	logic             room, in_icmp, take;
	logic [CNT_W:0]   len_x;
	summary_t         sum_s1;
	logic             valid_s1;

	assign room     = byte_count_q < CNT_W'(MAX_PACKET_BYTES);
	assign in_ready = !valid_s1 || sum_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		hl_n       = header_length_q;
		protocol_n = protocol_q;
		type_n     = type_q;
		ident_n    = ident_q;
		sent_s_n   = sent_s_q;
		sent_us_n  = sent_us_q;
		count_n    = byte_count_q;
		if (room && byte_count_q == '0)
			hl_n = {in_data.packet_byte[3:0], 2'b00};
		in_icmp = byte_count_q >= CNT_W'(hl_n);
		off     = byte_count_q - CNT_W'(hl_n);
		if (room) begin
			count_n = byte_count_q + 1'b1;
			if (byte_count_q == CNT_W'(PROTO_BYTE_POS))
				protocol_n = in_data.packet_byte;
			if (in_icmp) begin
				if (off == CNT_W'(OFF_TYPE))
					type_n = in_data.packet_byte;
				else if (off == CNT_W'(OFF_ID_LO))
					ident_n[7:0] = in_data.packet_byte;
				else if (off == CNT_W'(OFF_ID_HI))
					ident_n[15:8] = in_data.packet_byte;
				else if (off[CNT_W-1:2] == (CNT_W-2)'(OFF_SEC_WORD))
					sent_s_n = sent_s_q | (32'(in_data.packet_byte) << {off[1:0], 3'b000});
				else if (off[CNT_W-1:2] == (CNT_W-2)'(OFF_USEC_WORD))
					sent_us_n = sent_us_q | (32'(in_data.packet_byte) << {off[1:0], 3'b000});
			end
		end
		len_x = {1'b0, count_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			header_length_q <= '0;
			protocol_q      <= '0;
			type_q          <= '0;
			ident_q         <= '0;
			sent_s_q        <= '0;
			sent_us_q       <= '0;
		end else if (take) begin
			if (in_data.is_last) begin
				byte_count_q    <= '0;
				header_length_q <= '0;
				protocol_q      <= '0;
				type_q          <= '0;
				ident_q         <= '0;
				sent_s_q        <= '0;
				sent_us_q       <= '0;
			end else begin
				byte_count_q    <= count_n;
				header_length_q <= hl_n;
				protocol_q      <= protocol_n;
				type_q          <= type_n;
				ident_q         <= ident_n;
				sent_s_q        <= sent_s_n;
				sent_us_q       <= sent_us_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= take && in_data.is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_data.is_last) begin
			sum_s1.short_packet      <= len_x < (CNT_W+1)'(MIN_PACKET_BYTES);
			sum_s1.short_icmp        <= len_x < (CNT_W+1)'(hl_n) + (CNT_W+1)'(ICMP_HDR_BYTES);
			sum_s1.short_reply       <= len_x < (CNT_W+1)'(hl_n) + (CNT_W+1)'(ICMP_TS_END);
			sum_s1.protocol_byte     <= protocol_n;
			sum_s1.message_type      <= type_n;
			sum_s1.echo_identifier   <= ident_n;
			sum_s1.sent_seconds      <= sent_s_n;
			sum_s1.sent_microseconds <= sent_us_n;
			sum_s1.recv_seconds      <= in_data.recv_seconds;
			sum_s1.recv_microseconds <= in_data.recv_microseconds;
		end
	end

	assign sum_valid = valid_s1;
	assign sum_data  = sum_s1;

endmodule

### rtl/core/iemr_check.sv
// Verdict selection and the seconds-to-microseconds product.
module iemr_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [15:0]        own_identifier,
	input  logic               sum_valid,
	output logic               sum_ready,
	input  iemr_pkg::summary_t sum_data,
	output logic               part_valid,
	input  logic               part_ready,
	output iemr_pkg::partial_t part_data
);
	import iemr_pkg::*;

	verdict_t           verdict;
	logic signed [32:0] sec_diff;
	partial_t           part_s2;
	logic               valid_s2;

	always_comb begin
		priority if (sum_data.short_packet)
			verdict = VERDICT_TOO_SHORT;
		else if (sum_data.protocol_byte != PROTO_ICMP)
			verdict = VERDICT_NOT_ICMP;
		else if (sum_data.short_icmp)
			verdict = VERDICT_TOO_SHORT;
		else if (sum_data.message_type != TYPE_ECHO_REPLY)
			verdict = VERDICT_NOT_REPLY;
		else if (sum_data.echo_identifier != own_identifier)
			verdict = VERDICT_ID_MISMATCH;
		else if (sum_data.short_reply)
			verdict = VERDICT_SHORT_REPLY;
		else
			verdict = VERDICT_ACCEPTED;
	end

	assign sec_diff  = $signed({1'b0, sum_data.recv_seconds})
	                 - $signed({1'b0, sum_data.sent_seconds});
	assign sum_ready = !valid_s2 || part_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (sum_ready) begin
			valid_s2 <= sum_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_valid && sum_ready) begin
			part_s2.verdict     <= verdict;
			part_s2.sec_product <= sec_diff * USEC_PER_SEC;
			part_s2.usec_diff   <= $signed({13'b0, sum_data.recv_microseconds})
			                     - $signed({1'b0, sum_data.sent_microseconds});
		end
	end

	assign part_valid = valid_s2;
	assign part_data  = part_s2;

endmodule

### rtl/core/iemr_result.sv
// Final sum, saturation to 32 bits and the output register.
module iemr_result (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                part_valid,
	output logic                part_ready,
	input  iemr_pkg::partial_t  part_data,
	output logic                out_valid,
	input  logic                out_ready,
	output iemr_pkg::out_word_t out_data
);
	import iemr_pkg::*;

	localparam logic signed [54:0] SAT_MAX = 55'sd2147483647;
	localparam logic signed [54:0] SAT_MIN = -55'sd2147483648;

	logic signed [54:0] total;
	logic signed [31:0] rtt;
	out_word_t          out_q;
	logic               valid_q;

	assign total = 55'(part_data.sec_product) + 55'(part_data.usec_diff);

	always_comb begin
		priority if (part_data.verdict != VERDICT_ACCEPTED)
			rtt = '0;
		else if (total > SAT_MAX)
			rtt = 32'sh7FFF_FFFF;
		else if (total < SAT_MIN)
			rtt = 32'sh8000_0000;
		else
			rtt = total[31:0];
	end

	assign part_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (part_ready) begin
			valid_q <= part_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (part_valid && part_ready) begin
			out_q.verdict       <= part_data.verdict;
			out_q.round_trip_us <= rtt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = out_q;

endmodule

### rtl/core/icmp_echo_reply_matcher.sv
// Each packet's verdict goes through the summary, check/multiply and output registers in order.
// Throughput: one packet byte per cycle while in_ready is high; capture, check/multiply
// and output registers hold one word each; bytes stop only while a summary waits in capture.
// Reset: arst_n clears the byte count, captured fields, own_identifier and all valid flags.
// The identifier register write port is always ready.
module icmp_echo_reply_matcher #(
	parameter int unsigned MAX_PACKET_BYTES = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  iemr_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output iemr_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);
	import iemr_pkg::*;

	logic [15:0] own_identifier_q;
	logic        sum_valid, sum_ready;
	summary_t    sum_data;
	logic        part_valid, part_ready;
	partial_t    part_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_identifier_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			own_identifier_q <= cfg_data;
		end
	end

	iemr_capture #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.sum_valid (sum_valid),
		.sum_ready (sum_ready),
		.sum_data  (sum_data)
	);

	iemr_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.own_identifier (own_identifier_q),
		.sum_valid      (sum_valid),
		.sum_ready      (sum_ready),
		.sum_data       (sum_data),
		.part_valid     (part_valid),
		.part_ready     (part_ready),
		.part_data      (part_data)
	);

	iemr_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.part_valid (part_valid),
		.part_ready (part_ready),
		.part_data  (part_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

### test/tb_icmp_echo_reply_matcher.sv
// Self-checking testbench for the ICMP echo reply matcher: byte-level predictor and scoreboard.
module tb_icmp_echo_reply_matcher;
	import iemr_pkg::*;

	localparam int unsigned FRAME_CAP = 2048;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_word_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_word_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// predictor state
	logic [11:0] seen_bytes;
	logic [5:0]  hdr_len;
	logic [7:0]  proto;
	logic [7:0]  mtype;
	logic [15:0] echo_id;
	logic [31:0] sent_sec;
	logic [31:0] sent_usec;
	logic [15:0] own_id;

	out_word_t   verdict_q[$];
	logic [7:0]  frame[$];
	int          mismatches;
	int          items_sent;
	bit          calm;
	int          stall_left;

	icmp_echo_reply_matcher #(
		.MAX_PACKET_BYTES(FRAME_CAP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("FAIL");
		$finish;
	end

	// Predict the effect of one accepted byte; the last byte yields one verdict word
	function automatic void track_byte(input in_word_t w);
		int        off;
		int        len;
		longint    wide_rs;
		longint    wide_rus;
		longint    wide_ss;
		longint    wide_sus;
		longint    rtt;
		out_word_t res;
		if (seen_bytes < FRAME_CAP) begin
			if (seen_bytes == 0)
				hdr_len = {w.packet_byte[3:0], 2'b00};
			if (seen_bytes == PROTO_BYTE_POS)
				proto = w.packet_byte;
			if (seen_bytes >= hdr_len) begin
				off = int'(seen_bytes) - int'(hdr_len);
				if (off == OFF_TYPE)
					mtype = w.packet_byte;
				else if (off == OFF_ID_LO)
					echo_id[7:0] = w.packet_byte;
				else if (off == OFF_ID_HI)
					echo_id[15:8] = w.packet_byte;
				else if (off >= 8 && off <= 11)
					sent_sec = sent_sec | (32'(w.packet_byte) << (8 * (off - 8)));
				else if (off >= 12 && off <= 15)
					sent_usec = sent_usec | (32'(w.packet_byte) << (8 * (off - 12)));
			end
			seen_bytes = seen_bytes + 1'b1;
		end
		if (!w.is_last)
			return;
		len = int'(seen_bytes);
		res.round_trip_us = '0;
		if (len < MIN_PACKET_BYTES)
			res.verdict = VERDICT_TOO_SHORT;
		else if (proto != PROTO_ICMP)
			res.verdict = VERDICT_NOT_ICMP;
		else if (len < int'(hdr_len) + ICMP_HDR_BYTES)
			res.verdict = VERDICT_TOO_SHORT;
		else if (mtype != TYPE_ECHO_REPLY)
			res.verdict = VERDICT_NOT_REPLY;
		else if (echo_id != own_id)
			res.verdict = VERDICT_ID_MISMATCH;
		else if (len < int'(hdr_len) + ICMP_TS_END)
			res.verdict = VERDICT_SHORT_REPLY;
		else begin
			res.verdict = VERDICT_ACCEPTED;
			wide_rs  = w.recv_seconds;
			wide_rus = w.recv_microseconds;
			wide_ss  = sent_sec;
			wide_sus = sent_usec;
			rtt = (wide_rs - wide_ss) * 1000000 + (wide_rus - wide_sus);
			if (rtt > 64'sd2147483647)
				rtt = 64'sd2147483647;
			if (rtt < -64'sd2147483648)
				rtt = -64'sd2147483648;
			res.round_trip_us = rtt[31:0];
		end
		verdict_q.push_back(res);
		seen_bytes = '0;
		hdr_len    = '0;
		proto      = '0;
		mtype      = '0;
		echo_id    = '0;
		sent_sec   = '0;
		sent_usec  = '0;
	endfunction

	function automatic void place(input int pos, input logic [7:0] v);
		if (pos < frame.size())
			frame[pos] = v;
	endfunction

	// Random filler, then header and ICMP fields; later writes win where they overlap
	function automatic void build_frame(input int ihl, input logic [7:0] prot,
			input logic [7:0] typ, input logic [15:0] id, input logic [31:0] ssec,
			input logic [31:0] susec, input int total);
		int hl;
		frame.delete();
		repeat (total) frame.push_back(8'($urandom));
		hl = ihl * 4;
		place(0, {4'h4, 4'(ihl)});
		place(PROTO_BYTE_POS, prot);
		place(hl + OFF_TYPE, typ);
		place(hl + OFF_ID_LO, id[7:0]);
		place(hl + OFF_ID_HI, id[15:8]);
		for (int k = 0; k < 4; k++) begin
			place(hl + 8 + k, ssec[8 * k +: 8]);
			place(hl + 12 + k, susec[8 * k +: 8]);
		end
	endfunction

	task automatic send_word(input in_word_t w);
		@(negedge clk);
		if (!calm && $urandom_range(7, 0) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(18, 1)) @(negedge clk);
		end
		in_data  = w;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track_byte(w);
		items_sent++;
	endtask

	task automatic send_frame(input logic [31:0] rs, input logic [19:0] rus);
		in_word_t w;
		foreach (frame[i]) begin
			w.packet_byte = frame[i];
			w.is_last     = (i == frame.size() - 1);
			w.recv_seconds      = w.is_last ? rs : $urandom;
			w.recv_microseconds = w.is_last ? rus : 20'($urandom_range(999999, 0));
			send_word(w);
		end
	endtask

	// Hold the sender until every verdict is back, plus a margin for the pipeline
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_own_id(input logic [15:0] v);
		@(negedge clk);
		cfg_data  = v;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		own_id = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_reset_identifier();
		build_frame(5, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h0000, 32'd7, 32'd250, 28);
		send_frame(32'd7, 20'd900);
	endtask

	task automatic test_verdicts();
		drain();
		write_own_id(16'hFFFF);
		build_frame(5, PROTO_ICMP, TYPE_ECHO_REPLY, own_id, 32'd1, 32'd1, 1);
		send_frame(32'd1, 20'd1);
		build_frame(5, PROTO_ICMP, TYPE_ECHO_REPLY, own_id, 32'd1, 32'd1, 9);
		send_frame(32'd1, 20'd1);
		build_frame(5, 8'd6, TYPE_ECHO_REPLY, own_id, 32'd1, 32'd1, 28);
		send_frame(32'd1, 20'd1);
		build_frame(5, PROTO_ICMP, TYPE_ECHO_REPLY, own_id, 32'd1, 32'd1, 27);
		send_frame(32'd1, 20'd1);
		build_frame(5, PROTO_ICMP, 8'd8, own_id, 32'd1, 32'd1, 36);
		send_frame(32'd1, 20'd1);
		build_frame(5, PROTO_ICMP, TYPE_ECHO_REPLY, 16'h1234, 32'd1, 32'd1, 36);
		send_frame(32'd1, 20'd1);
		build_frame(5, PROTO_ICMP, TYPE_ECHO_REPLY, own_id, 32'd1, 32'd1, 35);
		send_frame(32'd1, 20'd1);
		build_frame(5, PROTO_ICMP, TYPE_ECHO_REPLY, own_id, 32'd100, 32'd999999, 36);
		send_frame(32'd101, 20'd0);
		build_frame(15, PROTO_ICMP, TYPE_ECHO_REPLY, own_id, 32'd9, 32'd0, 80);
		send_frame(32'd9, 20'd999999);
		// all-ones and all-zero words
		frame.delete();
		repeat (12) frame.push_back(8'hFF);
		send_frame(32'hFFFF_FFFF, 20'hFFFFF);
		frame.delete();
		repeat (10) frame.push_back(8'h00);
		send_frame(32'h0, 20'h0);
	endtask

	task automatic test_timestamps();
		// header length zero: byte 0 doubles as the type, byte 9 is a seconds byte
		build_frame(0, PROTO_ICMP, TYPE_ECHO_REPLY, own_id, 32'h0000_0100, 32'd5, 16);
		send_frame(32'h0000_0101, 20'd5);
		build_frame(5, PROTO_ICMP, TYPE_ECHO_REPLY, own_id, 32'd0, 32'd0, 36);
		send_frame(32'hFFFF_FFFF, 20'd999999);
		build_frame(5, PROTO_ICMP, TYPE_ECHO_REPLY, own_id, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 36);
		send_frame(32'd0, 20'd0);
		build_frame(5, PROTO_ICMP, TYPE_ECHO_REPLY, own_id, 32'd0, 32'd0, 36);
		send_frame(32'd2147, 20'd483647);
		build_frame(5, PROTO_ICMP, TYPE_ECHO_REPLY, own_id, 32'd2147, 32'd483648, 36);
		send_frame(32'd0, 20'd0);
		// send microseconds far out of range, receive microseconds at field maximum
		build_frame(5, PROTO_ICMP, TYPE_ECHO_REPLY, own_id, 32'd5, 32'hFFFF_FFFF, 36);
		send_frame(32'd5000, 20'hFFFFF);
	endtask

	task automatic test_random_traffic();
		int          base;
		int          pick;
		int          ihl;
		int          total;
		logic [31:0] ssec;
		logic [31:0] rs;
		logic [19:0] rus;
		base = items_sent;
		for (int phase = 0; phase < 5; phase++) begin
			drain();
			if (phase == 0)
				write_own_id(16'hFFFF);
			else if (phase == 1)
				write_own_id(16'h0000);
			else
				write_own_id(16'($urandom));
			while (items_sent - base < (phase + 1) * 130) begin
				if (items_sent - base >= 570)
					calm = 1'b1;
				pick = $urandom_range(99, 0);
				rus  = 20'($urandom_range(999999, 0));
				if (pick < 70) begin
					ihl   = ($urandom_range(3, 0) == 0) ? $urandom_range(15, 5) : 5;
					ssec  = $urandom;
					total = ihl * 4 + 16 + $urandom_range(12, 0);
					if ($urandom_range(9, 0) == 0)
						total = $urandom_range(ihl * 4 + 16, 1);
					build_frame(ihl, PROTO_ICMP, TYPE_ECHO_REPLY,
						($urandom_range(9, 0) == 0) ? 16'($urandom) : own_id,
						ssec, 32'($urandom_range(999999, 0)), total);
					rs = ssec + $urandom_range(2, 0);
				end else if (pick < 90) begin
					ihl = $urandom_range(15, 0);
					build_frame(ihl,
						$urandom_range(1, 0) ? PROTO_ICMP : 8'($urandom),
						$urandom_range(1, 0) ? TYPE_ECHO_REPLY : 8'($urandom),
						$urandom_range(1, 0) ? own_id : 16'($urandom),
						$urandom, $urandom, $urandom_range(ihl * 4 + 24, 1));
					rs = $urandom;
				end else begin
					frame.delete();
					repeat ($urandom_range(40, 1)) frame.push_back(8'($urandom));
					rs = $urandom;
				end
				send_frame(rs, rus);
			end
		end
	endtask

	// receiver back-pressure in bursts
	always @(negedge clk) begin
		if (calm)
			out_ready = 1'b1;
		else if (stall_left > 0) begin
			stall_left--;
			out_ready = 1'b0;
		end else if ($urandom_range(5, 0) == 0) begin
			stall_left = $urandom_range(17, 0);
			out_ready = 1'b0;
		end else
			out_ready = 1'b1;
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t unexpected word: expected none, actual verdict %0d rtt %0d",
					$time, out_data.verdict, out_data.round_trip_us);
				mismatches++;
			end else begin
				want = verdict_q.pop_front();
				if (out_data.verdict !== want.verdict) begin
					$display("%0t verdict: expected %0d, actual %0d",
						$time, want.verdict, out_data.verdict);
					mismatches++;
				end
				if (out_data.round_trip_us !== want.round_trip_us) begin
					$display("%0t round_trip_us: expected %0d, actual %0d",
						$time, want.round_trip_us, out_data.round_trip_us);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_ready  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		calm       = 1'b0;
		stall_left = 0;
		mismatches = 0;
		items_sent = 0;
		seen_bytes = '0;
		hdr_len    = '0;
		proto      = '0;
		mtype      = '0;
		echo_id    = '0;
		sent_sec   = '0;
		sent_usec  = '0;
		own_id     = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_identifier();
		test_verdicts();
		test_timestamps();
		test_random_traffic();

		@(negedge clk);
		in_valid = 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
